/* design/spt_pkg.sv */
// ----------------------------------------------------------------------------
// spt_pkg
// Shared widths and codes for the segment proximity table.
// ----------------------------------------------------------------------------
package spt_pkg;

    localparam int COORD_W  = 24;
    localparam int TOL_W    = COORD_W - 1;
    localparam int SLOT_W   = 6;
    localparam int CAPACITY = 64;
    localparam int CNT_W    = 7;
    localparam int MODE_W   = 2;
    localparam int STAT_W   = 2;

    // arithmetic widths of the shared multiply-accumulate unit
    localparam int DIFF_W = COORD_W + 1;
    localparam int OPND_W = 27;
    localparam int PROD_W = 2 * OPND_W;
    localparam int ACC_W  = 104;
    localparam int LEN_W  = 50;
    localparam int TOL2_W = 2 * TOL_W;
    localparam int MAG_W  = 50;
    localparam int LIMB_W = 26;

    // transaction modes
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADSLOT = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE    = 2'd3;

endpackage

/* design/segment_proximity_table_core.sv */
// ----------------------------------------------------------------------------
// segment_proximity_table_core
// Ordered table of 3-D segments with add, remove and a first-hit find.
//
// Input channel s_*: one transaction carries a mode (add, remove, find), a
// slot, a point, a segment end and a tolerance. Output channel m_*: one
// transaction per input with a status and a slot.
// Only one transaction is processed at a time; s_ready is high while the block idles.
// A remove shifts the later entries down, with one read and one write of the
// segment memory per shifted entry. A find scans the entries in slot order,
// skips zero-length segments and tests the others with an end-clamped test
// or with the projected test.
// The find rate is set by the single 27x27 multiply-accumulate unit, which
// takes one partial product per cycle for every test of an entry.
// Reset empties the table; segment memory contents are not cleared.
// A stalled output holds its result; a finished transaction waits in the done
// state until the output register is free, then returns to idle for new input.
// ----------------------------------------------------------------------------
module segment_proximity_table_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [spt_pkg::MODE_W-1:0]   s_mode,
    input  logic [spt_pkg::SLOT_W-1:0]   s_slot,
    input  logic signed [spt_pkg::COORD_W-1:0] s_point_x,
    input  logic signed [spt_pkg::COORD_W-1:0] s_point_y,
    input  logic signed [spt_pkg::COORD_W-1:0] s_point_z,
    input  logic signed [spt_pkg::COORD_W-1:0] s_end_x,
    input  logic signed [spt_pkg::COORD_W-1:0] s_end_y,
    input  logic signed [spt_pkg::COORD_W-1:0] s_end_z,
    input  logic [spt_pkg::TOL_W-1:0]    s_tolerance,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [spt_pkg::STAT_W-1:0]   m_status,
    output logic [spt_pkg::SLOT_W-1:0]   m_found_slot
);
    import spt_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] sz;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic signed [COORD_W-1:0] ez;
    } seg_t;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_FRD  = 7'b0000010,
        S_LOAD = 7'b0000100,
        S_CALC = 7'b0001000,
        S_RMRD = 7'b0010000,
        S_RMWR = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        K_START = 2'd0,
        K_END   = 2'd1,
        K_CROSS = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_26 = 2'd1,
        SH_27 = 2'd2,
        SH_52 = 2'd3
    } shift_t;

    localparam int STP_W = 5;
    localparam logic [STP_W-1:0] STP_DECIDE = 5'd8;
    localparam logic [STP_W-1:0] STP_END_A  = 5'd13;
    localparam logic [STP_W-1:0] STP_END_C  = 5'd29;

    // segment memory
    seg_t mem [CAPACITY];
    seg_t rd_data_reg;
    logic mem_we;
    logic [SLOT_W-1:0] mem_waddr, mem_raddr;
    seg_t mem_wdata;

    // control state
    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [STP_W-1:0] stp_reg, stp_next;
    kind_t kind_reg, kind_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [SLOT_W-1:0] m_found_slot_reg, m_found_slot_next;

    // query and per-entry operands
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic [TOL_W-1:0] tol_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [DIFF_W-1:0] wx_reg, wy_reg, wz_reg;
    logic signed [DIFF_W-1:0] qx_reg, qy_reg, qz_reg;
    logic [LEN_W-1:0] len2_reg;
    logic [TOL2_W-1:0] tol2_reg;
    logic [MAG_W-1:0] cx_reg, cy_reg, cz_reg;

    // multiply-accumulate unit
    logic signed [OPND_W-1:0] op_a, op_b;
    shift_t op_sh;
    logic op_en, op_sub, op_clr;
    logic signed [PROD_W-1:0] prod_reg;
    logic pv_reg, psub_reg, pclr_reg;
    shift_t psh_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] addend, acc_base, len2_ext, tol2_ext;
    logic [ACC_W-1:0] acc_abs;

    logic ent_done, ent_hit;
    logic signed [DIFF_W-1:0] ux, uy, uz;
    logic out_free;
    logic [CNT_W-1:0] idx_inc;

    function automatic logic signed [OPND_W-1:0] ext_d(input logic signed [DIFF_W-1:0] v);
        return {{(OPND_W-DIFF_W){v[DIFF_W-1]}}, v};
    endfunction

    function automatic logic signed [OPND_W-1:0] ext_u(input logic [LIMB_W-1:0] v);
        return {{(OPND_W-LIMB_W){1'b0}}, v};
    endfunction

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_found_slot = m_found_slot_reg;
    assign out_free     = !m_valid_reg || m_ready;
    assign idx_inc      = {1'b0, idx_reg} + CNT_W'(1);

    // memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // memory address and write selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = rd_data_reg;
        mem_raddr = idx_reg;
        if (state_reg == S_IDLE && s_valid && s_mode == MODE_ADD
                && count_reg != CNT_W'(CAPACITY)) begin
            mem_we    = 1'b1;
            mem_waddr = count_reg[SLOT_W-1:0];
            mem_wdata = '{sx: s_point_x, sy: s_point_y, sz: s_point_z,
                          ex: s_end_x, ey: s_end_y, ez: s_end_z};
        end else if (state_reg == S_RMWR) begin
            mem_we = 1'b1;
        end
        if (state_reg == S_RMRD) begin
            mem_raddr = idx_inc[SLOT_W-1:0];
        end
    end

    // end-test vector: from segment start or from segment end
    always_comb begin
        if (kind_reg == K_START) begin
            ux = wx_reg;
            uy = wy_reg;
            uz = wz_reg;
        end else begin
            ux = qx_reg;
            uy = qy_reg;
            uz = qz_reg;
        end
    end

    // per-entry operation schedule
    always_comb begin
        op_en  = 1'b0;
        op_a   = '0;
        op_b   = '0;
        op_sh  = SH_0;
        op_sub = 1'b0;
        op_clr = 1'b0;
        if (state_reg == S_CALC) begin
            case (stp_reg)
                5'd0: begin
                    op_en = 1'b1; op_clr = 1'b1;
                    op_a = ext_u(LIMB_W'(tol_reg)); op_b = ext_u(LIMB_W'(tol_reg));
                end
                5'd1: begin
                    op_en = 1'b1; op_clr = 1'b1; op_a = ext_d(dx_reg); op_b = ext_d(dx_reg);
                end
                5'd2: begin op_en = 1'b1; op_a = ext_d(dy_reg); op_b = ext_d(dy_reg); end
                5'd3: begin op_en = 1'b1; op_a = ext_d(dz_reg); op_b = ext_d(dz_reg); end
                5'd4: begin
                    op_en = 1'b1; op_clr = 1'b1; op_a = ext_d(wx_reg); op_b = ext_d(dx_reg);
                end
                5'd5: begin op_en = 1'b1; op_a = ext_d(wy_reg); op_b = ext_d(dy_reg); end
                5'd6: begin op_en = 1'b1; op_a = ext_d(wz_reg); op_b = ext_d(dz_reg); end
                5'd9: begin
                    op_en = 1'b1; op_clr = 1'b1;
                    if (kind_reg == K_CROSS) begin
                        op_a = ext_d(wy_reg); op_b = ext_d(dz_reg);
                    end else begin
                        op_a = ext_d(ux); op_b = ext_d(ux);
                    end
                end
                5'd10: begin
                    op_en = 1'b1;
                    if (kind_reg == K_CROSS) begin
                        op_sub = 1'b1; op_a = ext_d(wz_reg); op_b = ext_d(dy_reg);
                    end else begin
                        op_a = ext_d(uy); op_b = ext_d(uy);
                    end
                end
                5'd11: begin
                    op_en = 1'b1;
                    if (kind_reg == K_CROSS) begin
                        op_clr = 1'b1; op_a = ext_d(wz_reg); op_b = ext_d(dx_reg);
                    end else begin
                        op_a = ext_d(uz); op_b = ext_d(uz);
                    end
                end
                5'd12: begin
                    op_en = (kind_reg == K_CROSS); op_sub = 1'b1;
                    op_a = ext_d(wx_reg); op_b = ext_d(dz_reg);
                end
                5'd13: begin
                    op_en = (kind_reg == K_CROSS); op_clr = 1'b1;
                    op_a = ext_d(wx_reg); op_b = ext_d(dy_reg);
                end
                5'd14: begin
                    op_en = 1'b1; op_sub = 1'b1; op_a = ext_d(wy_reg); op_b = ext_d(dx_reg);
                end
                // squares of the cross product, split in 26-bit limbs
                5'd15: begin
                    op_en = 1'b1; op_clr = 1'b1; op_sh = SH_52;
                    op_a = ext_u(LIMB_W'(cx_reg[MAG_W-1:LIMB_W]));
                    op_b = ext_u(LIMB_W'(cx_reg[MAG_W-1:LIMB_W]));
                end
                5'd16: begin
                    op_en = 1'b1; op_sh = SH_27;
                    op_a = ext_u(LIMB_W'(cx_reg[MAG_W-1:LIMB_W]));
                    op_b = ext_u(cx_reg[LIMB_W-1:0]);
                end
                5'd17: begin
                    op_en = 1'b1;
                    op_a = ext_u(cx_reg[LIMB_W-1:0]); op_b = ext_u(cx_reg[LIMB_W-1:0]);
                end
                5'd18: begin
                    op_en = 1'b1; op_sh = SH_52;
                    op_a = ext_u(LIMB_W'(cy_reg[MAG_W-1:LIMB_W]));
                    op_b = ext_u(LIMB_W'(cy_reg[MAG_W-1:LIMB_W]));
                end
                5'd19: begin
                    op_en = 1'b1; op_sh = SH_27;
                    op_a = ext_u(LIMB_W'(cy_reg[MAG_W-1:LIMB_W]));
                    op_b = ext_u(cy_reg[LIMB_W-1:0]);
                end
                5'd20: begin
                    op_en = 1'b1;
                    op_a = ext_u(cy_reg[LIMB_W-1:0]); op_b = ext_u(cy_reg[LIMB_W-1:0]);
                end
                5'd21: begin
                    op_en = 1'b1; op_sh = SH_52;
                    op_a = ext_u(LIMB_W'(cz_reg[MAG_W-1:LIMB_W]));
                    op_b = ext_u(LIMB_W'(cz_reg[MAG_W-1:LIMB_W]));
                end
                5'd22: begin
                    op_en = 1'b1; op_sh = SH_27;
                    op_a = ext_u(LIMB_W'(cz_reg[MAG_W-1:LIMB_W]));
                    op_b = ext_u(cz_reg[LIMB_W-1:0]);
                end
                5'd23: begin
                    op_en = 1'b1;
                    op_a = ext_u(cz_reg[LIMB_W-1:0]); op_b = ext_u(cz_reg[LIMB_W-1:0]);
                end
                // subtract tol^2 * len^2 in limbs
                5'd24: begin
                    op_en = 1'b1; op_sub = 1'b1; op_sh = SH_52;
                    op_a = ext_u(LIMB_W'(tol2_reg[TOL2_W-1:LIMB_W]));
                    op_b = ext_u(LIMB_W'(len2_reg[LEN_W-1:LIMB_W]));
                end
                5'd25: begin
                    op_en = 1'b1; op_sub = 1'b1; op_sh = SH_26;
                    op_a = ext_u(LIMB_W'(tol2_reg[TOL2_W-1:LIMB_W]));
                    op_b = ext_u(len2_reg[LIMB_W-1:0]);
                end
                5'd26: begin
                    op_en = 1'b1; op_sub = 1'b1; op_sh = SH_26;
                    op_a = ext_u(tol2_reg[LIMB_W-1:0]);
                    op_b = ext_u(LIMB_W'(len2_reg[LEN_W-1:LIMB_W]));
                end
                5'd27: begin
                    op_en = 1'b1; op_sub = 1'b1;
                    op_a = ext_u(tol2_reg[LIMB_W-1:0]); op_b = ext_u(len2_reg[LIMB_W-1:0]);
                end
                default: begin
                    op_en = 1'b0;
                end
            endcase
        end
    end

    // product stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= op_en;
        end
        prod_reg <= op_a * op_b;
        psh_reg  <= op_sh;
        psub_reg <= op_sub;
        pclr_reg <= op_clr;
    end

    // accumulate stage
    always_comb begin
        case (psh_reg)
            SH_26:   addend = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg} <<< 26;
            SH_27:   addend = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg} <<< 27;
            SH_52:   addend = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg} <<< 52;
            default: addend = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        endcase
        acc_base = pclr_reg ? '0 : acc_reg;
        acc_abs  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        len2_ext = {{(ACC_W-LEN_W){1'b0}}, len2_reg};
        tol2_ext = {{(ACC_W-TOL2_W){1'b0}}, tol2_reg};
    end

    always_ff @(posedge aclk) begin
        if (pv_reg) begin
            acc_reg <= psub_reg ? acc_base - addend : acc_base + addend;
        end
    end

    // operand registers for the scan
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            px_reg  <= s_point_x;
            py_reg  <= s_point_y;
            pz_reg  <= s_point_z;
            tol_reg <= s_tolerance;
        end
        if (state_reg == S_LOAD) begin
            dx_reg <= DIFF_W'(rd_data_reg.ex) - DIFF_W'(rd_data_reg.sx);
            dy_reg <= DIFF_W'(rd_data_reg.ey) - DIFF_W'(rd_data_reg.sy);
            dz_reg <= DIFF_W'(rd_data_reg.ez) - DIFF_W'(rd_data_reg.sz);
            wx_reg <= DIFF_W'(px_reg) - DIFF_W'(rd_data_reg.sx);
            wy_reg <= DIFF_W'(py_reg) - DIFF_W'(rd_data_reg.sy);
            wz_reg <= DIFF_W'(pz_reg) - DIFF_W'(rd_data_reg.sz);
            qx_reg <= DIFF_W'(px_reg) - DIFF_W'(rd_data_reg.ex);
            qy_reg <= DIFF_W'(py_reg) - DIFF_W'(rd_data_reg.ey);
            qz_reg <= DIFF_W'(pz_reg) - DIFF_W'(rd_data_reg.ez);
        end
        if (state_reg == S_CALC) begin
            if (stp_reg == 5'd2) tol2_reg <= acc_reg[TOL2_W-1:0];
            if (stp_reg == 5'd5) len2_reg <= acc_reg[LEN_W-1:0];
            if (stp_reg == 5'd12) cx_reg <= acc_abs[MAG_W-1:0];
            if (stp_reg == 5'd14) cy_reg <= acc_abs[MAG_W-1:0];
            if (stp_reg == 5'd16) cz_reg <= acc_abs[MAG_W-1:0];
        end
    end

    // entry outcome at the decision steps
    always_comb begin
        ent_done = 1'b0;
        ent_hit  = 1'b0;
        if (state_reg == S_CALC) begin
            if (stp_reg == STP_DECIDE && len2_reg == '0) begin
                ent_done = 1'b1;
            end else if (stp_reg == STP_END_A && kind_reg != K_CROSS) begin
                ent_done = 1'b1;
                ent_hit  = (acc_reg <= tol2_ext);
            end else if (stp_reg == STP_END_C) begin
                ent_done = 1'b1;
                ent_hit  = (acc_reg <= 0);
            end
        end
    end

    // control next state
    always_comb begin
        state_next        = state_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        stp_next          = stp_reg;
        kind_next         = kind_reg;
        res_status_next   = res_status_reg;
        res_slot_next     = res_slot_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_found_slot_next = m_found_slot_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_status_next = ST_OK;
                    res_slot_next   = '0;
                    state_next      = S_DONE;
                    case (s_mode)
                        MODE_ADD: begin
                            if (count_reg == CNT_W'(CAPACITY)) begin
                                res_status_next = ST_FULL;
                            end else begin
                                res_slot_next = count_reg[SLOT_W-1:0];
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_REMOVE: begin
                            if ({1'b0, s_slot} >= count_reg) begin
                                res_status_next = ST_BADSLOT;
                            end else begin
                                idx_next   = s_slot;
                                state_next = S_RMRD;
                            end
                        end
                        MODE_FIND: begin
                            if (count_reg == '0) begin
                                res_status_next = ST_NONE;
                            end else begin
                                idx_next   = '0;
                                state_next = S_FRD;
                            end
                        end
                        default: begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_RMRD: begin
                if (idx_inc < count_reg) begin
                    state_next = S_RMWR;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_RMWR: begin
                idx_next   = idx_inc[SLOT_W-1:0];
                state_next = S_RMRD;
            end
            S_FRD: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                stp_next   = '0;
                state_next = S_CALC;
            end
            S_CALC: begin
                stp_next = stp_reg + STP_W'(1);
                if (stp_reg == STP_DECIDE) begin
                    if (acc_reg[ACC_W-1] || acc_reg == '0) begin
                        kind_next = K_START;
                    end else if (acc_reg >= len2_ext) begin
                        kind_next = K_END;
                    end else begin
                        kind_next = K_CROSS;
                    end
                end
                if (ent_done) begin
                    if (ent_hit) begin
                        res_status_next = ST_OK;
                        res_slot_next   = idx_reg;
                        state_next      = S_DONE;
                    end else if (idx_inc == count_reg) begin
                        res_status_next = ST_NONE;
                        res_slot_next   = '0;
                        state_next      = S_DONE;
                    end else begin
                        idx_next   = idx_inc[SLOT_W-1:0];
                        state_next = S_FRD;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_status_next     = res_status_reg;
                    m_found_slot_next = res_slot_reg;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg          <= idx_next;
        stp_reg          <= stp_next;
        kind_reg         <= kind_next;
        res_status_reg   <= res_status_next;
        res_slot_reg     <= res_slot_next;
        m_status_reg     <= m_status_next;
        m_found_slot_reg <= m_found_slot_next;
    end

    // checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("segment count above capacity");

    a_add_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode == MODE_ADD && count_reg != CNT_W'(CAPACITY)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("add did not grow the table");

    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_found_slot == '0)
        else $error("nonzero slot on failed transaction");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CALC |-> {1'b0, idx_reg} < count_reg)
        else $error("scan index beyond table");

endmodule
